// File: hdl/video_echo_trail_filter_assert.svh
// ----------------------------------------------------------------------------
// Video echo trail filter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VIDEO_ECHO_TRAIL_FILTER_ASSERT_SVH
`define VIDEO_ECHO_TRAIL_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VETF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("video echo trail filter check failed");

// The consequent must hold in the cycle after the antecedent.
`define VETF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("video echo trail filter check failed");

`endif

// File: hdl/vetf_pkg.sv
// ----------------------------------------------------------------------------
// Video echo trail filter package
// Shared types and constants for the echo trail filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vetf_pkg;

  localparam int FRAME_PIXELS = 65536;
  localparam int ADDR_W       = $clog2(FRAME_PIXELS);

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [15:0] pixel_index;
    logic [7:0]  in_blue;
    logic [7:0]  in_green;
    logic [7:0]  in_red;
    logic [7:0]  in_alpha;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
  } echo_t;

  typedef struct packed {
    logic [6:0] fade_step;
    logic       bright_mode;
    logic       keep_red;
    logic       keep_green;
    logic       keep_blue;
    logic [3:0] strobe_skip;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_FADE_STEP   = 3'd0,
    REG_BRIGHT_MODE = 3'd1,
    REG_KEEP_RED    = 3'd2,
    REG_KEEP_GREEN  = 3'd3,
    REG_KEEP_BLUE   = 3'd4,
    REG_STROBE_SKIP = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    MODE_COPY    = 2'd0,
    MODE_SKIP    = 2'd1,
    MODE_PROCESS = 2'd2
  } mode_e;

endpackage

// File: hdl/vetf_frame_ctrl.sv
// ----------------------------------------------------------------------------
// Echo trail frame sequencer
// Tracks the first frame and the strobe counter and tags each pixel with
// the way its frame is handled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vetf_frame_ctrl
  import vetf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [15:0] pixel_index,
  input  logic [3:0]  strobe_skip,
  output mode_e       mode
);

  logic       first_pending;
  logic       first_pending_next;
  logic       copying;
  logic       copying_next;
  logic       processed;
  logic       processed_next;
  logic [3:0] skip_cnt;
  logic [3:0] skip_cnt_next;

  always_comb begin
    first_pending_next = first_pending;
    copying_next       = copying;
    processed_next     = processed;
    skip_cnt_next      = skip_cnt;
    if (pixel_index == 16'd0) begin
      if (first_pending) begin
        first_pending_next = 1'b0;
        copying_next       = 1'b1;
        processed_next     = 1'b0;
      end else begin
        copying_next = 1'b0;
        if (skip_cnt < strobe_skip) begin
          skip_cnt_next  = skip_cnt + 4'd1;
          processed_next = 1'b0;
        end else begin
          skip_cnt_next  = 4'd0;
          processed_next = 1'b1;
        end
      end
    end
    if (copying_next) begin
      mode = MODE_COPY;
    end else if (processed_next) begin
      mode = MODE_PROCESS;
    end else begin
      mode = MODE_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
      copying       <= 1'b1;
      processed     <= 1'b0;
      skip_cnt      <= 4'd0;
    end else if (accept) begin
      first_pending <= first_pending_next;
      copying       <= copying_next;
      processed     <= processed_next;
      skip_cnt      <= skip_cnt_next;
    end
  end

endmodule

// File: hdl/vetf_store.sv
// ----------------------------------------------------------------------------
// Echo frame store
// One write and one registered read per cycle, with a bypass for a read of
// the pixel being written in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vetf_store
  import vetf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  rd_en,
  input  addr_t rd_addr,
  input  logic  wr_en,
  input  addr_t wr_addr,
  input  echo_t wr_data,
  output echo_t rd_data
);

  echo_t mem [FRAME_PIXELS];
  echo_t mem_q;
  echo_t byp;
  logic  hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      byp   <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (rd_en) begin
      hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = hit ? byp : mem_q;

endmodule

// File: hdl/vetf_fade.sv
// ----------------------------------------------------------------------------
// Echo fade and select
// Fades the stored pixel and picks the faded, the input or the unchanged stored pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vetf_fade
  import vetf_pkg::*;
(
  input  cfg_t  cfg,
  input  mode_e mode,
  input  pix_t  pix,
  input  echo_t stored,
  output echo_t result
);

  function automatic logic [7:0] fade_channel(
    input logic [7:0] v,
    input logic       keep,
    input logic [6:0] step,
    input logic       bright
  );
    logic [7:0] s;
    logic [8:0] sum;
    begin
      if (bright) begin
        s = keep ? 8'd0 : {1'b0, step};
        fade_channel = (v > s) ? v - s : 8'd0;
      end else begin
        s   = keep ? 8'd255 : {1'b0, step};
        sum = {1'b0, v} + {1'b0, s};
        fade_channel = sum[8] ? 8'd255 : sum[7:0];
      end
    end
  endfunction

  logic [7:0] fb;
  logic [7:0] fg;
  logic [7:0] fr;
  logic       take_input;
  echo_t      in_echo;
  echo_t      faded;

  always_comb begin
    fb = fade_channel(stored.out_blue,  cfg.keep_blue,  cfg.fade_step, cfg.bright_mode);
    fg = fade_channel(stored.out_green, cfg.keep_green, cfg.fade_step, cfg.bright_mode);
    fr = fade_channel(stored.out_red,   cfg.keep_red,   cfg.fade_step, cfg.bright_mode);
    if (cfg.bright_mode) begin
      take_input = (fb <= pix.in_blue) || (fg <= pix.in_green) || (fr <= pix.in_red);
    end else begin
      take_input = (fb > pix.in_blue) || (fg > pix.in_green) || (fr > pix.in_red);
    end
    in_echo = '{out_blue: pix.in_blue, out_green: pix.in_green,
                out_red: pix.in_red, out_alpha: pix.in_alpha};
    faded   = '{out_blue: fb, out_green: fg, out_red: fr,
                out_alpha: stored.out_alpha};
    case (mode)
      MODE_COPY:    result = in_echo;
      MODE_SKIP:    result = stored;
      MODE_PROCESS: result = take_input ? in_echo : faded;
      default:      result = stored;
    endcase
  end

endmodule

// File: hdl/video_echo_trail_filter.sv
// ----------------------------------------------------------------------------
// Video echo trail filter
// Echo effect on a BGRA pixel stream using a frame store of the last echo.
// ----------------------------------------------------------------------------
// The filter takes one pixel per clock while the output is not stalled and
// returns one echo pixel per pixel. A pixel taken into the input register is
// faded and selected there and loaded into the output register. The fade
// and select logic is a single pass between the input and output registers,
// so a new pixel can be taken as the last is loaded into the output register,
// and a stall on the output holds both stages and the input. The frame store
// does at most one read and one write per cycle, and a pixel that reads
// the entry written by the pixel just ahead of it gets that value through a
// bypass. The store has no reset, so the first frame after reset must cover
// every pixel index that later frames use. Configuration should be written
// only while no pixel is in flight.
`timescale 1ns / 1ps

module video_echo_trail_filter
  import vetf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pix_valid,
  output logic       pix_stall,
  input  pix_t       pix,
  output logic       echo_valid,
  input  logic       echo_stall,
  output echo_t      echo,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data
);

  cfg_t  cfg;
  logic  pix_accept;
  logic  s1_valid;
  logic  s1_adv;
  pix_t  s1_pix;
  mode_e s1_mode;
  mode_e in_mode;
  echo_t stored;
  echo_t result;
  logic  store_we;
  logic  s1_copy;
  addr_t in_addr;
  addr_t s1_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{fade_step: 7'd19, bright_mode: 1'b0, keep_red: 1'b0,
               keep_green: 1'b0, keep_blue: 1'b0, strobe_skip: 4'd0};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FADE_STEP:   cfg.fade_step   <= cfg_data;
        REG_BRIGHT_MODE: cfg.bright_mode <= cfg_data[0];
        REG_KEEP_RED:    cfg.keep_red    <= cfg_data[0];
        REG_KEEP_GREEN:  cfg.keep_green  <= cfg_data[0];
        REG_KEEP_BLUE:   cfg.keep_blue   <= cfg_data[0];
        REG_STROBE_SKIP: cfg.strobe_skip <= cfg_data[3:0];
        default:         cfg <= cfg;
      endcase
    end
  end

  assign s1_adv     = !echo_valid || !echo_stall;
  assign pix_stall  = s1_valid && !s1_adv;
  assign pix_accept = pix_valid && !pix_stall;
  assign in_addr    = pix.pixel_index[ADDR_W-1:0];
  assign s1_addr    = s1_pix.pixel_index[ADDR_W-1:0];
  assign store_we   = s1_valid && s1_adv && (s1_mode != MODE_SKIP);
  assign s1_copy    = store_we && (s1_mode == MODE_COPY);

  vetf_frame_ctrl u_frame_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (pix_accept),
    .pixel_index (pix.pixel_index),
    .strobe_skip (cfg.strobe_skip),
    .mode        (in_mode)
  );

  vetf_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (pix_accept),
    .rd_addr (in_addr),
    .wr_en   (store_we),
    .wr_addr (s1_addr),
    .wr_data (result),
    .rd_data (stored)
  );

  vetf_fade u_fade (
    .cfg    (cfg),
    .mode   (s1_mode),
    .pix    (s1_pix),
    .stored (stored),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_pix  <= pix;
      s1_mode <= in_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_valid <= 1'b0;
    end else if (s1_adv) begin
      echo_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      echo <= result;
    end
  end

`include "video_echo_trail_filter_assert.svh"

`VETF_ASSERT_SAME(a_stall_needs_item, pix_stall, s1_valid)
`VETF_ASSERT_NEXT(a_held_item_stays, s1_valid && echo_valid && echo_stall, s1_valid)
`VETF_ASSERT_NEXT(a_copy_passes_blue, s1_copy, echo.out_blue == $past(s1_pix.in_blue))
`VETF_ASSERT_NEXT(a_copy_passes_alpha, s1_copy, echo.out_alpha == $past(s1_pix.in_alpha))

endmodule
